// ----- rtl/bcm_pkg.sv -----
// ----------------------------------------------------------------------------
// bcm_pkg: shared types and constants for the BGR555 color math pixel block
// Register indexes, the configuration bundle and the blend bit masks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bcm_pkg;

  localparam int COLOR_W  = 15;
  localparam int SOURCE_W = 3;
  localparam int BRIGHT_W = 4;
  localparam int MASK_W   = 7;
  localparam int PIXEL_W  = BRIGHT_W + COLOR_W;
  localparam int INDEX_W  = 3;
  localparam int WDATA_W  = 15;
  localparam int IN_W     = 40;
  localparam int OUT_W    = 24;

  localparam logic [15:0] LOW_BITS   = 16'h0421;
  localparam logic [15:0] CARRY_BITS = 16'h8420;
  localparam logic [15:0] HALVE_MASK = 16'h7bde;

  localparam logic [SOURCE_W-1:0] EXCLUDED_SOURCE = 3'd5;
  localparam logic [SOURCE_W-1:0] BACKDROP_SOURCE = 3'd6;

  typedef enum logic [INDEX_W-1:0] {
    REG_SUBTRACT_MODE    = 3'd0,
    REG_USE_SUB_SCREEN   = 3'd1,
    REG_HALVE_ENABLE     = 3'd2,
    REG_MATH_ENABLE_MASK = 3'd3,
    REG_FIXED_COLOR      = 3'd4,
    REG_BRIGHTNESS       = 3'd5,
    REG_HIRES_MODE       = 3'd6
  } reg_index_t;

  typedef struct packed {
    logic                subtract_mode;
    logic                use_sub_screen;
    logic                halve_enable;
    logic [MASK_W-1:0]   math_enable_mask;
    logic [COLOR_W-1:0]  fixed_color;
    logic [BRIGHT_W-1:0] brightness;
    logic                hires_mode;
  } cfg_t;

endpackage

`default_nettype wire

// ----- rtl/bgr555_color_math_pixel.sv -----
// ----------------------------------------------------------------------------
// bgr555_color_math_pixel: console style color math on a pixel stream
// Blends main and sub screen colors and emits brightness-tagged BGR555 words.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake        | content
//  s_*      | in        | tvalid / tready  | one pixel column per word
//  m_*      | out       | tvalid / tready  | one result word, tlast on final
//  write_*  | in        | write_enable     | register index and data
//
// One input register feeds the blend logic, one output register holds the
// result. Normal mode: one word in and out per cycle unless the output stalls.
// Hires mode: two output words per input, and a new input is taken only as the
// second word moves to the output register. Synchronous reset empties both
// registers and clears the configuration. A stalled output holds its word; the
// input register frees in the cycle its last result moves to the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bgr555_color_math_pixel (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  // main_bgr[14:0], main_source[17:15], sub_bgr[32:18], sub_source[35:33],
  // main_visible[36], math_window[37], zero[39:38]
  input  wire logic [bcm_pkg::IN_W-1:0]      s_tdata,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // pixel_word[18:0], zero[23:19]
  output logic      [bcm_pkg::OUT_W-1:0]     m_tdata,
  output logic                               m_tlast,
  input  wire logic                          write_enable,
  input  wire logic [bcm_pkg::INDEX_W-1:0]   write_index,
  input  wire logic [bcm_pkg::WDATA_W-1:0]   write_data
);
  import bcm_pkg::*;

  cfg_t cfg;

  logic                s1_valid;
  logic                s1_phase;
  logic [COLOR_W-1:0]  s1_main_bgr;
  logic [SOURCE_W-1:0] s1_main_source;
  logic [COLOR_W-1:0]  s1_sub_bgr;
  logic [SOURCE_W-1:0] s1_sub_source;
  logic                s1_main_visible;
  logic                s1_math_window;

  logic               out_valid;
  logic [PIXEL_W-1:0] out_word;
  logic               out_last;

  logic [COLOR_W-1:0] main_pix, sub_pix;
  logic               emit_sub, out_load, s1_done, in_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (write_enable) begin
      case (reg_index_t'(write_index))
        REG_SUBTRACT_MODE:    cfg.subtract_mode    <= write_data[0];
        REG_USE_SUB_SCREEN:   cfg.use_sub_screen   <= write_data[0];
        REG_HALVE_ENABLE:     cfg.halve_enable     <= write_data[0];
        REG_MATH_ENABLE_MASK: cfg.math_enable_mask <= write_data[MASK_W-1:0];
        REG_FIXED_COLOR:      cfg.fixed_color      <= write_data[COLOR_W-1:0];
        REG_BRIGHTNESS:       cfg.brightness       <= write_data[BRIGHT_W-1:0];
        REG_HIRES_MODE:       cfg.hires_mode       <= write_data[0];
        default: ;
      endcase
    end
  end

  bcm_pixel_math u_main (
    .cfg            (cfg),
    .primary_color  (s1_main_bgr),
    .primary_source (s1_main_source),
    .operand_color  (s1_sub_bgr),
    .operand_source (s1_sub_source),
    .main_visible   (s1_main_visible),
    .math_window    (s1_math_window),
    .color          (main_pix)
  );

  bcm_pixel_math u_sub (
    .cfg            (cfg),
    .primary_color  (s1_sub_bgr),
    .primary_source (s1_sub_source),
    .operand_color  (s1_main_bgr),
    .operand_source (s1_main_source),
    .main_visible   (s1_main_visible),
    .math_window    (s1_math_window),
    .color          (sub_pix)
  );

  always_comb begin
    emit_sub = cfg.hires_mode && !s1_phase;
    out_load = s1_valid && (!out_valid || m_tready);
    s1_done  = out_load && !emit_sub;
    s_tready = !s1_valid || s1_done;
    in_take  = s_tvalid && s_tready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_phase <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
      s1_phase <= 1'b0;
    end else if (s1_done) begin
      s1_valid <= 1'b0;
    end else if (out_load) begin
      s1_phase <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_main_bgr     <= s_tdata[14:0];
      s1_main_source  <= s_tdata[17:15];
      s1_sub_bgr      <= s_tdata[32:18];
      s1_sub_source   <= s_tdata[35:33];
      s1_main_visible <= s_tdata[36];
      s1_math_window  <= s_tdata[37];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_word <= {cfg.brightness, (emit_sub ? sub_pix : main_pix)};
      out_last <= !emit_sub;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(OUT_W-PIXEL_W){1'b0}}, out_word};
  assign m_tlast  = out_last;

endmodule

`default_nettype wire

// ----- rtl/bcm_pixel_math.sv -----
// ----------------------------------------------------------------------------
// bcm_pixel_math: color math for one pixel
// Picks the operand, applies window gating and blends per 5-bit component.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bcm_pixel_math (
  input  wire bcm_pkg::cfg_t                  cfg,
  input  wire logic [bcm_pkg::COLOR_W-1:0]    primary_color,
  input  wire logic [bcm_pkg::SOURCE_W-1:0]   primary_source,
  input  wire logic [bcm_pkg::COLOR_W-1:0]    operand_color,
  input  wire logic [bcm_pkg::SOURCE_W-1:0]   operand_source,
  input  wire logic                           main_visible,
  input  wire logic                           math_window,
  output logic      [bcm_pkg::COLOR_W-1:0]    color
);
  import bcm_pkg::*;

  logic [15:0] a, b, ab_x;
  logic [15:0] s, s_adj, c, r_add, r_hadd;
  logic [15:0] d, w, r_sub, r_hsub;
  logic [MASK_W:0] mask_ext;
  logic        math_on, halve;
  logic [15:0] blended;

  always_comb begin
    a = {1'b0, (main_visible ? primary_color : {COLOR_W{1'b0}})};
    b = {1'b0, (cfg.use_sub_screen ? operand_color : cfg.fixed_color)};
    ab_x = a ^ b;

    // saturating add and halved add, carries caught at component tops
    s      = a + b;
    s_adj  = s - (ab_x & LOW_BITS);
    c      = s_adj & CARRY_BITS;
    r_add  = (s - c) | (c - (c >> 5));
    r_hadd = s_adj >> 1;

    // subtract with borrow guard bits, clamped at zero
    d      = a - b + CARRY_BITS;
    w      = (d - (ab_x & CARRY_BITS)) & CARRY_BITS;
    r_sub  = (d - w) & (w - (w >> 5));
    r_hsub = (r_sub & HALVE_MASK) >> 1;

    // source seven has no mask bit
    mask_ext = {1'b0, cfg.math_enable_mask};
    math_on  = (primary_source != EXCLUDED_SOURCE) && mask_ext[primary_source] && math_window;
    halve    = cfg.halve_enable && main_visible &&
               (!cfg.use_sub_screen || (operand_source != BACKDROP_SOURCE));

    if (cfg.subtract_mode) begin
      blended = halve ? r_hsub : r_sub;
    end else begin
      blended = halve ? r_hadd : r_add;
    end

    if (!main_visible && !math_window) begin
      color = '0;
    end else if (math_on) begin
      color = blended[COLOR_W-1:0];
    end else begin
      color = a[COLOR_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/bcm_checker.sv -----
// ----------------------------------------------------------------------------
// bcm_checker: port level checks for the color math pixel block
// Watches output stalls, reset, hires word pairs and padding bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bcm_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        m_tvalid,
  input wire logic                        m_tready,
  input wire logic [bcm_pkg::OUT_W-1:0]   m_tdata,
  input wire logic                        m_tlast
);
  import bcm_pkg::*;

  // stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output word changed under stall");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

  // the main pixel of a hires pair is ready right behind the sub pixel
  a_pair: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> m_tvalid && m_tlast)
    else $error("hires pair broken");

  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[OUT_W-1:PIXEL_W] == '0))
    else $error("output padding not zero");

endmodule

bind bgr555_color_math_pixel bcm_checker u_bcm_checker (
  .clk          (clk),
  .rst          (rst),
  .m_tvalid     (m_tvalid),
  .m_tready     (m_tready),
  .m_tdata      (m_tdata),
  .m_tlast      (m_tlast)
);

`default_nettype wire

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for bgr555_color_math_pixel
// Drives pixel columns with random valid gaps and output stalls, predicts each
// result word by a color math model or a typed word, compares field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import bcm_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS = 170;
  localparam logic [SOURCE_W-1:0] UNMASKED_SOURCE = 3'd7;

  typedef struct packed {
    logic [COLOR_W-1:0]  main_bgr;
    logic [SOURCE_W-1:0] main_source;
    logic [COLOR_W-1:0]  sub_bgr;
    logic [SOURCE_W-1:0] sub_source;
    logic                main_visible;
    logic                math_window;
  } pixel_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel_word;
    logic               last;
  } result_t;

  typedef struct {
    cfg_t               cfg;
    pixel_t             px;
    logic               typed;
    logic [PIXEL_W-1:0] word;
  } stim_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [IN_W-1:0]     s_tdata = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OUT_W-1:0]    m_tdata;
  logic                m_tlast;
  logic                write_enable = 1'b0;
  logic [INDEX_W-1:0]  write_index = '0;
  logic [WDATA_W-1:0]  write_data = '0;

  logic                typed_valid = 1'b0;
  logic [PIXEL_W-1:0]  typed_word = '0;

  cfg_t                active_cfg = '0;
  cfg_t                loaded_cfg = '0;
  result_t             expected_words[$];
  stim_row_t           directed_rows[$];
  int                  mismatches = 0;
  int                  cycles = 0;
  int                  gap_pct = 0;
  int                  stall_pct = 0;
  int                  stall_left = 0;

  bgr555_color_math_pixel uut (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tlast      (m_tlast),
    .write_enable (write_enable),
    .write_index  (write_index),
    .write_data   (write_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // per-component blend of two BGR555 colors
  function automatic logic [COLOR_W-1:0] blend_bgr(logic [COLOR_W-1:0] a,
                                                   logic [COLOR_W-1:0] b,
                                                   logic sub, logic halve);
    logic [31:0] x, y, s, c, d, w, r;
    x = 32'(a);
    y = 32'(b);
    if (!sub) begin
      if (!halve) begin
        s = x + y;
        c = (s - ((x ^ y) & 32'(LOW_BITS))) & 32'(CARRY_BITS);
        r = (s - c) | (c - (c >> 5));
      end else begin
        r = (x + y - ((x ^ y) & 32'(LOW_BITS))) >> 1;
      end
    end else begin
      d = x - y + 32'(CARRY_BITS);
      w = (d - ((x ^ y) & 32'(CARRY_BITS))) & 32'(CARRY_BITS);
      r = (d - w) & (w - (w >> 5));
      if (halve) r = (r & 32'(HALVE_MASK)) >> 1;
    end
    return r[COLOR_W-1:0];
  endfunction

  function automatic logic [COLOR_W-1:0] screen_color(cfg_t cfg,
      logic [COLOR_W-1:0] pc, logic [SOURCE_W-1:0] ps,
      logic [COLOR_W-1:0] oc, logic [SOURCE_W-1:0] os, logic vis, logic win);
    logic halve;
    if (!cfg.use_sub_screen) begin
      os = BACKDROP_SOURCE;
      oc = cfg.fixed_color;
    end
    if (!vis) begin
      if (!win) return '0;
      pc = '0;
    end
    if (ps != EXCLUDED_SOURCE && ps != UNMASKED_SOURCE && cfg.math_enable_mask[ps] && win)
    begin
      halve = cfg.halve_enable && vis && (!cfg.use_sub_screen || os != BACKDROP_SOURCE);
      return blend_bgr(pc, oc, cfg.subtract_mode, halve);
    end
    return pc;
  endfunction

  function automatic cfg_t make_cfg(logic sub, logic use_sub, logic halve,
      logic [MASK_W-1:0] mask, logic [COLOR_W-1:0] fixed,
      logic [BRIGHT_W-1:0] bright, logic hires);
    cfg_t c;
    c.subtract_mode    = sub;
    c.use_sub_screen   = use_sub;
    c.halve_enable     = halve;
    c.math_enable_mask = mask;
    c.fixed_color      = fixed;
    c.brightness       = bright;
    c.hires_mode       = hires;
    return c;
  endfunction

  function automatic void add_row(cfg_t cfg, logic [COLOR_W-1:0] mc,
      logic [SOURCE_W-1:0] ms, logic [COLOR_W-1:0] sc, logic [SOURCE_W-1:0] ss,
      logic vis, logic win, logic typed, logic [PIXEL_W-1:0] word);
    stim_row_t row;
    row.cfg = cfg;
    row.px = '{main_bgr: mc, main_source: ms, sub_bgr: sc, sub_source: ss,
               main_visible: vis, math_window: win};
    row.typed = typed;
    row.word = word;
    directed_rows.push_back(row);
  endfunction

  function automatic int idle_length();
    if ($urandom_range(9) == 0) return $urandom_range(8, 30);
    return $urandom_range(1, 3);
  endfunction

  // components biased to 0 and 31 so saturation and clamping get hit
  function automatic logic [COLOR_W-1:0] rand_bgr();
    logic [COLOR_W-1:0] c;
    for (int i = 0; i < 3; i++) begin
      case ($urandom_range(3))
        0: c[i*5 +: 5] = 5'd0;
        1: c[i*5 +: 5] = 5'd31;
        default: c[i*5 +: 5] = 5'($urandom);
      endcase
    end
    return c;
  endfunction

  function automatic pixel_t rand_pixel();
    pixel_t px;
    px.main_bgr     = rand_bgr();
    px.main_source  = 3'($urandom_range(7));
    px.sub_bgr      = rand_bgr();
    px.sub_source   = 3'($urandom_range(7));
    px.main_visible = ($urandom_range(3) != 0);
    px.math_window  = ($urandom_range(3) != 0);
    return px;
  endfunction

  task automatic load_settings(cfg_t c);
    write_enable <= 1'b1;
    write_index <= REG_SUBTRACT_MODE;
    write_data <= WDATA_W'(c.subtract_mode);
    @(negedge clk);
    write_index <= REG_USE_SUB_SCREEN;
    write_data <= WDATA_W'(c.use_sub_screen);
    @(negedge clk);
    write_index <= REG_HALVE_ENABLE;
    write_data <= WDATA_W'(c.halve_enable);
    @(negedge clk);
    write_index <= REG_MATH_ENABLE_MASK;
    write_data <= WDATA_W'(c.math_enable_mask);
    @(negedge clk);
    write_index <= REG_FIXED_COLOR;
    write_data <= WDATA_W'(c.fixed_color);
    @(negedge clk);
    write_index <= REG_BRIGHTNESS;
    write_data <= WDATA_W'(c.brightness);
    @(negedge clk);
    write_index <= REG_HIRES_MODE;
    write_data <= WDATA_W'(c.hires_mode);
    @(negedge clk);
    write_enable <= 1'b0;
    loaded_cfg = c;
  endtask

  task automatic send_pixel(pixel_t px, logic typed, logic [PIXEL_W-1:0] word);
    int gap;
    gap = (gap_pct != 0 && $urandom_range(99) < gap_pct) ? idle_length() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {2'b00, px.math_window, px.main_visible, px.sub_source, px.sub_bgr,
                px.main_source, px.main_bgr};
    typed_valid <= typed;
    typed_word <= word;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // output stalls
  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left = stall_left - 1;
      m_tready <= 1'b0;
    end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
      stall_left = idle_length() - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_pixels
    logic [COLOR_W-1:0] main_px, sub_px;
    result_t want;
    if (!rst) begin
      if (write_enable) begin
        case (reg_index_t'(write_index))
          REG_SUBTRACT_MODE:    active_cfg.subtract_mode = write_data[0];
          REG_USE_SUB_SCREEN:   active_cfg.use_sub_screen = write_data[0];
          REG_HALVE_ENABLE:     active_cfg.halve_enable = write_data[0];
          REG_MATH_ENABLE_MASK: active_cfg.math_enable_mask = write_data[MASK_W-1:0];
          REG_FIXED_COLOR:      active_cfg.fixed_color = write_data[COLOR_W-1:0];
          REG_BRIGHTNESS:       active_cfg.brightness = write_data[BRIGHT_W-1:0];
          REG_HIRES_MODE:       active_cfg.hires_mode = write_data[0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        if (typed_valid) begin
          expected_words.push_back('{pixel_word: typed_word, last: 1'b1});
        end else begin
          main_px = screen_color(active_cfg, s_tdata[14:0], s_tdata[17:15],
                                 s_tdata[32:18], s_tdata[35:33], s_tdata[36], s_tdata[37]);
          if (active_cfg.hires_mode) begin
            sub_px = screen_color(active_cfg, s_tdata[32:18], s_tdata[35:33],
                                  s_tdata[14:0], s_tdata[17:15], s_tdata[36], s_tdata[37]);
            expected_words.push_back('{pixel_word: {active_cfg.brightness, sub_px},
                                       last: 1'b0});
          end
          expected_words.push_back('{pixel_word: {active_cfg.brightness, main_px},
                                     last: 1'b1});
        end
      end
      if (m_tvalid && m_tready) begin
        if (expected_words.size() == 0) begin
          $error("unexpected word: pixel_word %h last %b", m_tdata[PIXEL_W-1:0], m_tlast);
          mismatches++;
        end else begin
          want = expected_words.pop_front();
          if (m_tdata[PIXEL_W-1:0] != want.pixel_word) begin
            $error("pixel_word: expected %h, got %h", want.pixel_word, m_tdata[PIXEL_W-1:0]);
            mismatches++;
          end
          if (m_tlast != want.last) begin
            $error("last: expected %b, got %b", want.last, m_tlast);
            mismatches++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("bgr555_color_math_pixel: mismatch");
      $finish;
    end
  end

  initial begin : stimulus
    cfg_t add_max, sub_max, sub_halve, add_sub_halve, hires_mix, hires_sub, phase_cfg;
    add_max       = make_cfg(1'b0, 1'b0, 1'b0, 7'h7f, 15'h7fff, 4'hf, 1'b0);
    sub_max       = make_cfg(1'b1, 1'b0, 1'b0, 7'h7f, 15'h7fff, 4'h0, 1'b0);
    sub_halve     = make_cfg(1'b1, 1'b0, 1'b1, 7'h7f, 15'h0000, 4'h5, 1'b0);
    add_sub_halve = make_cfg(1'b0, 1'b1, 1'b1, 7'h7f, 15'h5555, 4'h3, 1'b0);
    hires_mix     = make_cfg(1'b0, 1'b1, 1'b1, 7'h5a, 15'h0000, 4'h9, 1'b1);
    hires_sub     = make_cfg(1'b1, 1'b0, 1'b0, 7'h7f, 15'h7fff, 4'hf, 1'b1);

    // reset values: no math, brightness 0
    add_row('0, 15'h7fff, 3'd0, 15'h0000, 3'd0, 1'b1, 1'b1, 1'b1, 19'h07fff);
    add_row('0, 15'h7fff, 3'd0, 15'h7fff, 3'd0, 1'b0, 1'b0, 1'b1, 19'h00000);
    add_row('0, 15'h7fff, 3'd0, 15'h7fff, 3'd0, 1'b0, 1'b1, 1'b1, 19'h00000);
    // saturating add against fixed white, source 5 and 7 pass through
    add_row(add_max, 15'h7fff, 3'd0, 15'h0000, 3'd0, 1'b1, 1'b1, 1'b1, 19'h7ffff);
    add_row(add_max, 15'h0000, 3'd6, 15'h0000, 3'd0, 1'b1, 1'b1, 1'b1, 19'h7ffff);
    add_row(add_max, 15'h1234, 3'd5, 15'h0000, 3'd0, 1'b1, 1'b1, 1'b1, 19'h79234);
    add_row(add_max, 15'h1234, 3'd7, 15'h0000, 3'd0, 1'b1, 1'b1, 1'b1, 19'h79234);
    add_row(add_max, 15'h1234, 3'd0, 15'h0000, 3'd0, 1'b1, 1'b0, 1'b1, 19'h79234);
    add_row(add_max, 15'h1234, 3'd0, 15'h0000, 3'd0, 1'b0, 1'b0, 1'b1, 19'h78000);
    add_row(add_max, 15'h1234, 3'd1, 15'h0000, 3'd0, 1'b0, 1'b1, 1'b1, 19'h7ffff);
    // subtract clamps at zero
    add_row(sub_max, 15'h7fff, 3'd0, 15'h0000, 3'd0, 1'b1, 1'b1, 1'b1, 19'h00000);
    add_row(sub_max, 15'h1234, 3'd2, 15'h0000, 3'd0, 1'b1, 1'b1, 1'b1, 19'h00000);
    add_row(sub_halve, 15'h7fff, 3'd1, 15'h0000, 3'd0, 1'b1, 1'b1, 1'b0, '0);
    add_row(sub_halve, 15'h4210, 3'd3, 15'h0000, 3'd0, 1'b0, 1'b1, 1'b0, '0);
    add_row(sub_halve, 15'h56b5, 3'd4, 15'h0000, 3'd0, 1'b1, 1'b1, 1'b0, '0);
    // sub screen operand, backdrop operand suppresses halving
    add_row(add_sub_halve, 15'h7c1f, 3'd0, 15'h03e0, 3'd6, 1'b1, 1'b1, 1'b0, '0);
    add_row(add_sub_halve, 15'h7c1f, 3'd0, 15'h03e0, 3'd2, 1'b1, 1'b1, 1'b0, '0);
    add_row(add_sub_halve, 15'h2108, 3'd6, 15'h7fff, 3'd5, 1'b1, 1'b1, 1'b0, '0);
    add_row(add_sub_halve, 15'h1234, 3'd5, 15'h6b5a, 3'd1, 1'b1, 1'b1, 1'b0, '0);
    // hires: sub word first
    add_row(hires_mix, 15'h7fff, 3'd1, 15'h7fff, 3'd3, 1'b1, 1'b1, 1'b0, '0);
    add_row(hires_mix, 15'h001f, 3'd5, 15'h03e0, 3'd7, 1'b1, 1'b1, 1'b0, '0);
    add_row(hires_mix, 15'h0000, 3'd6, 15'h7c00, 3'd4, 1'b0, 1'b1, 1'b0, '0);
    add_row(hires_mix, 15'h5555, 3'd2, 15'h2aaa, 3'd0, 1'b0, 1'b0, 1'b0, '0);
    add_row(hires_sub, 15'h7fff, 3'd0, 15'h0000, 3'd0, 1'b1, 1'b1, 1'b0, '0);
    add_row(hires_sub, 15'h0000, 3'd6, 15'h7fff, 3'd6, 1'b1, 1'b0, 1'b0, '0);

    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    gap_pct = 20;
    stall_pct = 20;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].cfg != loaded_cfg) begin
        drain();
        load_settings(directed_rows[i].cfg);
      end
      send_pixel(directed_rows[i].px, directed_rows[i].typed, directed_rows[i].word);
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: phase_cfg = make_cfg(1'b1, 1'b1, 1'b1, 7'h7f, 15'h7fff, 4'hf, 1'b1);
        1: phase_cfg = '0;
        default: phase_cfg = make_cfg(1'($urandom), 1'($urandom), 1'($urandom),
                                      ($urandom_range(2) == 0) ? 7'($urandom) : 7'h7f,
                                      rand_bgr(), 4'($urandom), 1'($urandom));
      endcase
      drain();
      load_settings(phase_cfg);
      gap_pct = (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 25 : 60);
      stall_pct = (p % 4 == 1) ? 0 : ((p % 2 == 0) ? 30 : 55);
      repeat (PHASE_ITEMS) send_pixel(rand_pixel(), 1'b0, '0);
    end

    drain();
    if (mismatches == 0) begin
      $display("bgr555_color_math_pixel: match");
    end else begin
      $display("bgr555_color_math_pixel: mismatch");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/bcm_pkg.sv
rtl/bcm_pixel_math.sv
rtl/bgr555_color_math_pixel.sv
rtl/bcm_checker.sv
bench/tb_top.sv
